/* src/http_request_header_parser_core_assert.svh */
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle and next-cycle implications, clocked on clk, off during reset.
`ifndef SYNTHESIS
`define HRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrp assertion failed");
`define HRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrp assertion failed");
`else
`define HRP_ASSERT_NOW(label, ante, cons)
`define HRP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/hrp_pkg.sv */
package hrp_pkg;

    localparam int TYPE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int PHASE_W = 3;
    localparam int LEN_W   = 5;
    localparam int IDLE_W  = 17;
    localparam int TMO_W   = 16;

    typedef enum logic [TYPE_W-1:0] {
        REQ_CONNECT    = 2'd0,
        REQ_BYTE       = 2'd1,
        REQ_TICK       = 2'd2,
        REQ_DISCONNECT = 2'd3
    } req_type_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_METHOD = 3'd1,
        PH_PATH   = 3'd2,
        PH_PROTO  = 3'd3,
        PH_LINE   = 3'd4,
        PH_HEADER = 3'd5,
        PH_BODY   = 3'd6
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS  = 3'd0,
        KIND_READY   = 3'd1,
        KIND_CHAR    = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_REFUSED = 3'd4
    } kind_t;

    typedef enum logic {
        CTL_RUN    = 1'b0,
        CTL_STREAM = 1'b1
    } ctl_state_t;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

    localparam logic [IDLE_W-1:0] IDLE_MAX      = 17'h1FFFF;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd1000;

    localparam int              ADDR_W           = 3;
    localparam logic            REG_IDLE_TIMEOUT = 1'b0;

endpackage

/* src/hrp_in_if.sv */
interface hrp_in_if;
    logic                         valid;
    logic                         ready;
    logic [hrp_pkg::TYPE_W-1:0]   req_type;
    logic [hrp_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

/* src/hrp_out_if.sv */
interface hrp_out_if;
    logic                          valid;
    logic                          ready;
    logic [hrp_pkg::KIND_W-1:0]    result_kind;
    logic [hrp_pkg::PHASE_W-1:0]   parse_state;
    logic [hrp_pkg::LEN_W-1:0]     path_length;
    logic [hrp_pkg::BYTE_W-1:0]    path_char;
    logic                          last;

    modport source (output valid, output result_kind, output parse_state,
                    output path_length, output path_char, output last, input ready);
    modport sink   (input valid, input result_kind, input parse_state,
                    input path_length, input path_char, input last, output ready);
endinterface

/* src/http_request_header_parser_core.sv */
// Channel   Dir  Role    Word
// req       in   sink    req_type, data_byte
// rsp       out  source  result_kind, parse_state, path_length, path_char, last
// apb       in   slave   idle_timeout_ticks at byte address 0
//
// One word per cycle on req while the output register is free or being taken.
// The request-completing byte yields a ready word, then one char word per
// path character, each first read from path memory into a register; req is
// held off during that run. Reset clears control state and sets the timeout
// to 1000; path memory contents are not cleared. A stall on rsp holds req.
`include "http_request_header_parser_core_assert.svh"

module http_request_header_parser_core #(
    parameter int PATH_CAPACITY = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    hrp_in_if.sink                        req,
    hrp_out_if.source                     rsp
);

    localparam int IDX_W = $clog2(PATH_CAPACITY);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(PATH_CAPACITY - 1);

    hrp_pkg::ctl_state_t             state_reg, state_next;
    hrp_pkg::phase_t                 phase_reg, phase_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [IDX_W-1:0]                char_idx_reg, char_idx_next;
    logic [hrp_pkg::IDLE_W-1:0]      idle_reg, idle_next;
    logic [hrp_pkg::TMO_W-1:0]       timeout_reg;
    logic                            data_ok_reg, data_ok_next;
    logic                            out_valid_reg, out_valid_next;
    hrp_pkg::kind_t                  out_kind_reg, out_kind_next;
    logic [hrp_pkg::BYTE_W-1:0]      out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;

    logic [hrp_pkg::BYTE_W-1:0]      path_mem [PATH_CAPACITY];
    logic [hrp_pkg::BYTE_W-1:0]      rd_data_reg;
    logic                            mem_we;

    logic                            slot_free;
    logic                            accept;
    logic                            advance;
    logic                            last_char;
    logic                            done;
    logic [IDX_W-1:0]                idx_inc;
    logic [7:0]                      idx_wide;
    logic                            cfg_write;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign advance   = (state_reg == hrp_pkg::CTL_STREAM) && slot_free && data_ok_reg;
    assign last_char = (char_idx_reg == idx_reg - 1'b1);
    assign idx_inc   = (idx_reg == IDX_TOP) ? idx_reg : idx_reg + 1'b1;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[hrp_pkg::ADDR_W-1] == hrp_pkg::REG_IDLE_TIMEOUT)
        begin
            prdata = 32'(timeout_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= hrp_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write && paddr[hrp_pkg::ADDR_W-1] == hrp_pkg::REG_IDLE_TIMEOUT)
        begin
            timeout_reg <= pwdata[hrp_pkg::TMO_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            path_mem[idx_reg] <= req.data_byte;
        end
        rd_data_reg <= path_mem[char_idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hrp_pkg::CTL_RUN:
            begin
                if (accept && done && idx_reg != '0)
                begin
                    state_next = hrp_pkg::CTL_STREAM;
                end
            end
            hrp_pkg::CTL_STREAM:
            begin
                if (advance && last_char)
                begin
                    state_next = hrp_pkg::CTL_RUN;
                end
            end
            default:
            begin
                state_next = hrp_pkg::CTL_RUN;
            end
        endcase
    end

    always_comb
    begin
        req.ready      = (state_reg == hrp_pkg::CTL_RUN) && slot_free;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        idle_next      = idle_reg;
        char_idx_next  = char_idx_reg;
        mem_we         = 1'b0;
        done           = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        data_ok_next   = (state_reg == hrp_pkg::CTL_STREAM) && !advance;

        if (accept)
        begin
            out_kind_next = hrp_pkg::KIND_STATUS;
            case (hrp_pkg::req_type_t'(req.req_type))
                hrp_pkg::REQ_CONNECT:
                begin
                    if (phase_reg == hrp_pkg::PH_IDLE)
                    begin
                        phase_next = hrp_pkg::PH_METHOD;
                        idle_next  = '0;
                    end
                    else
                    begin
                        out_kind_next = hrp_pkg::KIND_REFUSED;
                    end
                end
                hrp_pkg::REQ_BYTE:
                begin
                    idle_next = '0;
                    case (phase_reg)
                        hrp_pkg::PH_METHOD:
                        begin
                            if (req.data_byte == hrp_pkg::CHAR_SPACE)
                            begin
                                phase_next = hrp_pkg::PH_PATH;
                                idx_next   = '0;
                            end
                        end
                        hrp_pkg::PH_PATH:
                        begin
                            mem_we   = 1'b1;
                            idx_next = idx_inc;
                            if (req.data_byte == hrp_pkg::CHAR_SPACE)
                            begin
                                phase_next = hrp_pkg::PH_PROTO;
                                idx_next   = idx_inc - 1'b1;
                            end
                        end
                        hrp_pkg::PH_PROTO:
                        begin
                            if (req.data_byte == hrp_pkg::CHAR_LF)
                            begin
                                phase_next = hrp_pkg::PH_LINE;
                            end
                        end
                        hrp_pkg::PH_LINE:
                        begin
                            if (req.data_byte == hrp_pkg::CHAR_LF)
                            begin
                                phase_next = hrp_pkg::PH_BODY;
                                done       = 1'b1;
                            end
                            else if (req.data_byte != hrp_pkg::CHAR_CR)
                            begin
                                phase_next = hrp_pkg::PH_HEADER;
                            end
                        end
                        hrp_pkg::PH_HEADER:
                        begin
                            if (req.data_byte == hrp_pkg::CHAR_LF)
                            begin
                                phase_next = hrp_pkg::PH_LINE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                hrp_pkg::REQ_TICK:
                begin
                    if (phase_reg inside {[hrp_pkg::PH_METHOD:hrp_pkg::PH_HEADER]})
                    begin
                        if (idle_reg != hrp_pkg::IDLE_MAX)
                        begin
                            idle_next = idle_reg + 1'b1;
                        end
                        if (idle_reg > hrp_pkg::IDLE_W'(timeout_reg))
                        begin
                            phase_next    = hrp_pkg::PH_IDLE;
                            out_kind_next = hrp_pkg::KIND_TIMEOUT;
                        end
                    end
                end
                hrp_pkg::REQ_DISCONNECT:
                begin
                    phase_next = hrp_pkg::PH_IDLE;
                end
                default:
                begin
                end
            endcase
            out_valid_next = 1'b1;
            out_char_next  = '0;
            out_last_next  = 1'b1;
            if (done)
            begin
                out_kind_next = hrp_pkg::KIND_READY;
                out_last_next = (idx_reg == '0);
                char_idx_next = '0;
            end
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = hrp_pkg::KIND_CHAR;
            out_char_next  = rd_data_reg;
            out_last_next  = last_char;
            char_idx_next  = char_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrp_pkg::CTL_RUN;
            phase_reg     <= hrp_pkg::PH_IDLE;
            idx_reg       <= '0;
            char_idx_reg  <= '0;
            idle_reg      <= '0;
            data_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            char_idx_reg  <= char_idx_next;
            idle_reg      <= idle_next;
            data_ok_reg   <= data_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign idx_wide        = 8'(idx_reg);
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.parse_state = phase_reg;
    assign rsp.path_length = idx_wide[hrp_pkg::LEN_W-1:0];
    assign rsp.path_char   = out_char_reg;
    assign rsp.last        = out_last_reg;

    `HRP_ASSERT_NOW(a_stream_in_body, state_reg == hrp_pkg::CTL_STREAM, phase_reg == hrp_pkg::PH_BODY)
    `HRP_ASSERT_NOW(a_stream_idx_in_range, state_reg == hrp_pkg::CTL_STREAM, char_idx_reg < idx_reg)
    `HRP_ASSERT_NEXT(a_accept_loads_word, req.valid && req.ready, rsp.valid)
    `HRP_ASSERT_NOW(a_timeout_goes_idle, rsp.valid && rsp.result_kind == hrp_pkg::KIND_TIMEOUT, rsp.parse_state == hrp_pkg::PH_IDLE)

endmodule

/* verif/http_request_header_parser_core_tb.sv */
module http_request_header_parser_core_tb;

    localparam int PATH_CAP      = 32;
    localparam int DIR_ROWS      = 29;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;
    localparam logic [hrp_pkg::ADDR_W-1:0] TIMEOUT_ADDR =
        hrp_pkg::ADDR_W'(4 * hrp_pkg::REG_IDLE_TIMEOUT);

    typedef struct packed {
        hrp_pkg::kind_t                 kind;
        hrp_pkg::phase_t                phase;
        logic [hrp_pkg::LEN_W-1:0]      len;
        logic [hrp_pkg::BYTE_W-1:0]     ch;
        logic                           last;
    } result_word_t;

    typedef struct packed {
        hrp_pkg::req_type_t             req;
        logic [hrp_pkg::BYTE_W-1:0]     data;
        logic                           typed;
        result_word_t                   want;
    } dir_row_t;

    localparam result_word_t NO_TYPED = '0;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [hrp_pkg::ADDR_W-1:0]     paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    hrp_in_if  req_ch();
    hrp_out_if rsp_ch();

    http_request_header_parser_core #(
        .PATH_CAPACITY(PATH_CAP)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    hrp_pkg::phase_t                shadow_phase;
    logic [hrp_pkg::BYTE_W-1:0]     shadow_path [PATH_CAP];
    logic [hrp_pkg::LEN_W-1:0]      shadow_len;
    logic [hrp_pkg::IDLE_W-1:0]     shadow_idle;
    logic [hrp_pkg::TMO_W-1:0]      shadow_timeout;

    result_word_t       pending_rsp_words [$];
    dir_row_t           directed_rows [DIR_ROWS];

    int                 mismatch_count;
    int                 items_sent;
    int                 tick_odds;
    bit                 idling_on;
    bit                 hold_req;
    bit                 req_offered;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void queue_rsp_word(hrp_pkg::kind_t kind,
                                           logic [hrp_pkg::BYTE_W-1:0] ch, logic last);
        result_word_t w;
        w.kind  = kind;
        w.phase = shadow_phase;
        w.len   = shadow_len;
        w.ch    = ch;
        w.last  = last;
        pending_rsp_words.push_back(w);
    endfunction

    function automatic void advance_parser(hrp_pkg::req_type_t req,
                                           logic [hrp_pkg::BYTE_W-1:0] data);
        hrp_pkg::phase_t  entry_phase;
        hrp_pkg::kind_t   kind;
        int unsigned      pos;
        int unsigned      n;
        int unsigned      i;
        logic             over;
        entry_phase = shadow_phase;
        kind = hrp_pkg::KIND_STATUS;
        case (req)
            hrp_pkg::REQ_CONNECT:
            begin
                if (shadow_phase == hrp_pkg::PH_IDLE)
                begin
                    shadow_phase = hrp_pkg::PH_METHOD;
                    shadow_idle = '0;
                end
                else
                    kind = hrp_pkg::KIND_REFUSED;
            end
            hrp_pkg::REQ_BYTE:
            begin
                shadow_idle = '0;
                case (shadow_phase)
                    hrp_pkg::PH_METHOD:
                    begin
                        if (data == hrp_pkg::CHAR_SPACE)
                        begin
                            shadow_phase = hrp_pkg::PH_PATH;
                            shadow_len = '0;
                        end
                    end
                    hrp_pkg::PH_PATH:
                    begin
                        pos = shadow_len;
                        if (pos >= PATH_CAP)
                            pos = PATH_CAP - 1;
                        shadow_path[pos] = data;
                        pos++;
                        if (pos == PATH_CAP)
                            pos--;
                        if (data == hrp_pkg::CHAR_SPACE)
                        begin
                            shadow_phase = hrp_pkg::PH_PROTO;
                            pos--;
                        end
                        shadow_len = hrp_pkg::LEN_W'(pos);
                    end
                    hrp_pkg::PH_PROTO:
                    begin
                        if (data == hrp_pkg::CHAR_LF)
                            shadow_phase = hrp_pkg::PH_LINE;
                    end
                    hrp_pkg::PH_LINE:
                    begin
                        if (data == hrp_pkg::CHAR_LF)
                            shadow_phase = hrp_pkg::PH_BODY;
                        else if (data != hrp_pkg::CHAR_CR)
                            shadow_phase = hrp_pkg::PH_HEADER;
                    end
                    hrp_pkg::PH_HEADER:
                    begin
                        if (data == hrp_pkg::CHAR_LF)
                            shadow_phase = hrp_pkg::PH_LINE;
                    end
                    default:
                    begin
                    end
                endcase
                if (entry_phase == hrp_pkg::PH_LINE && shadow_phase == hrp_pkg::PH_BODY)
                begin
                    n = shadow_len;
                    if (n > PATH_CAP)
                        n = PATH_CAP;
                    queue_rsp_word(hrp_pkg::KIND_READY, '0, n == 0);
                    for (i = 0; i < n; i++)
                        queue_rsp_word(hrp_pkg::KIND_CHAR, shadow_path[i], i + 1 == n);
                    return;
                end
            end
            hrp_pkg::REQ_TICK:
            begin
                if (shadow_phase >= hrp_pkg::PH_METHOD && shadow_phase <= hrp_pkg::PH_HEADER)
                begin
                    over = shadow_idle > {1'b0, shadow_timeout};
                    if (shadow_idle < hrp_pkg::IDLE_MAX)
                        shadow_idle = shadow_idle + 1'b1;
                    if (over)
                    begin
                        shadow_phase = hrp_pkg::PH_IDLE;
                        kind = hrp_pkg::KIND_TIMEOUT;
                    end
                end
            end
            default:
                shadow_phase = hrp_pkg::PH_IDLE;
        endcase
        queue_rsp_word(kind, '0, 1'b1);
    endfunction

    function automatic logic [hrp_pkg::BYTE_W-1:0] random_byte_except(
        logic [hrp_pkg::BYTE_W-1:0] a, logic [hrp_pkg::BYTE_W-1:0] c);
        logic [hrp_pkg::BYTE_W-1:0] r;
        do
        begin
            r = hrp_pkg::BYTE_W'($urandom_range(0, 255));
        end
        while (r == a || r == c);
        return r;
    endfunction

    task automatic send_word(input hrp_pkg::req_type_t req,
                             input logic [hrp_pkg::BYTE_W-1:0] data);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            if (req_offered)
            begin
                req_ch.valid <= 1'b0;
                req_offered = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= req;
        req_ch.data_byte <= data;
        req_offered = 1'b1;
        @(negedge clk);
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);
        advance_parser(req, data);
        items_sent++;
    endtask

    task automatic release_req();
        if (req_offered)
        begin
            req_ch.valid <= 1'b0;
            req_offered = 1'b0;
        end
        @(posedge clk);
    endtask

    task automatic drain_rsp();
        release_req();
        wait (pending_rsp_words.size() == 0);
        @(posedge clk);
    endtask

    task automatic apb_transfer(input logic is_write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idle_timeout(input logic [hrp_pkg::TMO_W-1:0] limit);
        logic [31:0] rd;
        drain_rsp();
        apb_transfer(1'b1, {16'($urandom()), limit}, rd);
        shadow_timeout = limit;
        apb_transfer(1'b0, '0, rd);
        if (rd[hrp_pkg::TMO_W-1:0] !== limit)
            flag_mismatch($sformatf("timeout readback at %0t: expected %0d, got %0d",
                                    $time, limit, rd[hrp_pkg::TMO_W-1:0]));
    endtask

    task automatic send_noisy(input hrp_pkg::req_type_t req,
                              input logic [hrp_pkg::BYTE_W-1:0] data);
        int n;
        if ($urandom_range(0, 19) == 0)
            send_word(hrp_pkg::req_type_t'(hrp_pkg::TYPE_W'($urandom_range(0, 3))),
                      hrp_pkg::BYTE_W'($urandom_range(0, 255)));
        if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(hrp_pkg::REQ_TICK, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        send_word(req, data);
    endtask

    task automatic send_request();
        int n;
        int h;
        send_noisy(hrp_pkg::REQ_CONNECT, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
        n = $urandom_range(0, 4);
        repeat (n) send_noisy(hrp_pkg::REQ_BYTE,
                              random_byte_except(hrp_pkg::CHAR_SPACE, hrp_pkg::CHAR_SPACE));
        send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_SPACE);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
        repeat (n) send_noisy(hrp_pkg::REQ_BYTE,
                              random_byte_except(hrp_pkg::CHAR_SPACE, hrp_pkg::CHAR_SPACE));
        send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_SPACE);
        n = $urandom_range(0, 8);
        repeat (n) send_noisy(hrp_pkg::REQ_BYTE,
                              random_byte_except(hrp_pkg::CHAR_LF, hrp_pkg::CHAR_LF));
        if ($urandom_range(0, 1) == 1)
            send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_CR);
        send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_LF);
        h = $urandom_range(0, 2);
        repeat (h)
        begin
            send_noisy(hrp_pkg::REQ_BYTE,
                       random_byte_except(hrp_pkg::CHAR_LF, hrp_pkg::CHAR_CR));
            n = $urandom_range(0, 6);
            repeat (n) send_noisy(hrp_pkg::REQ_BYTE,
                                  random_byte_except(hrp_pkg::CHAR_LF, hrp_pkg::CHAR_LF));
            if ($urandom_range(0, 1) == 1)
                send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_CR);
            send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_LF);
        end
        if ($urandom_range(0, 1) == 1)
            send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_CR);
        send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_LF);
        n = $urandom_range(0, 3);
        repeat (n) send_noisy(hrp_pkg::REQ_BYTE, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0)
            send_noisy(hrp_pkg::REQ_DISCONNECT, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_traffic(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat (8) send_word(
                    hrp_pkg::req_type_t'(hrp_pkg::TYPE_W'($urandom_range(0, 3))),
                    hrp_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else
                send_request();
        end
    endtask

    task automatic send_long_idle(input int ticks);
        send_word(hrp_pkg::REQ_DISCONNECT, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
        send_word(hrp_pkg::REQ_CONNECT, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
        repeat (ticks) send_word(hrp_pkg::REQ_TICK, hrp_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    initial
    begin : rsp_sink
        int stall_left;
        int hold_left;
        bit took;
        result_word_t want;
        result_word_t got;
        stall_left = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            took = rsp_ch.valid && rsp_ch.ready;
            got = {rsp_ch.result_kind, rsp_ch.parse_state, rsp_ch.path_length,
                   rsp_ch.path_char, rsp_ch.last};
            @(posedge clk);
            if (took)
            begin
                if (pending_rsp_words.size() == 0)
                    flag_mismatch($sformatf("unexpected word at %0t: kind %0d state %0d",
                                            $time, got.kind, got.phase));
                else
                begin
                    want = pending_rsp_words.pop_front();
                    if (got !== want)
                        flag_mismatch($sformatf({"mismatch at %0t: expected kind %0d ",
                            "state %0d len %0d char %02h last %b, got kind %0d state %0d ",
                            "len %0d char %02h last %b"}, $time,
                            want.kind, want.phase, want.len, want.ch, want.last,
                            got.kind, got.phase, got.len, got.ch, got.last));
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if (idling_on && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 10);
            rsp_ch.ready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial
    begin : stimulus
        int i;
        shadow_phase   = hrp_pkg::PH_IDLE;
        shadow_len     = '0;
        shadow_idle    = '0;
        shadow_timeout = hrp_pkg::TIMEOUT_RESET;
        mismatch_count = 0;
        items_sent     = 0;
        tick_odds      = 0;
        idling_on      = 1'b1;
        hold_req       = 1'b0;
        req_offered    = 1'b0;

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= hrp_pkg::REQ_CONNECT;
        req_ch.data_byte <= '0;

        directed_rows = '{
            '{hrp_pkg::REQ_TICK, 8'h00, 1'b1,
              '{hrp_pkg::KIND_STATUS, hrp_pkg::PH_IDLE, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_BYTE, 8'h41, 1'b1,
              '{hrp_pkg::KIND_STATUS, hrp_pkg::PH_IDLE, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_DISCONNECT, 8'hFF, 1'b1,
              '{hrp_pkg::KIND_STATUS, hrp_pkg::PH_IDLE, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_CONNECT, 8'h00, 1'b1,
              '{hrp_pkg::KIND_STATUS, hrp_pkg::PH_METHOD, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_CONNECT, 8'h00, 1'b1,
              '{hrp_pkg::KIND_REFUSED, hrp_pkg::PH_METHOD, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_TICK, 8'h00, 1'b1,
              '{hrp_pkg::KIND_STATUS, hrp_pkg::PH_METHOD, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_BYTE,       8'h47, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_SPACE, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       8'h00, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       8'hFF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       8'h2F, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_SPACE, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       8'h48, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_CR, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_LF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_CR, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       8'h58, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_LF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_LF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       8'h5A, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_TICK,       8'hFF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_CONNECT,    8'hFF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_DISCONNECT, 8'h00, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_CONNECT,    8'h00, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_SPACE, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_SPACE, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE,       hrp_pkg::CHAR_LF, 1'b0, NO_TYPED},
            '{hrp_pkg::REQ_BYTE, hrp_pkg::CHAR_LF, 1'b1,
              '{hrp_pkg::KIND_READY, hrp_pkg::PH_BODY, 5'd0, 8'h00, 1'b1}},
            '{hrp_pkg::REQ_DISCONNECT, 8'hFF, 1'b0, NO_TYPED}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_word(directed_rows[i].req, directed_rows[i].data);
            if (directed_rows[i].typed)
                pending_rsp_words[pending_rsp_words.size() - 1] = directed_rows[i].want;
        end

        set_idle_timeout(16'd0);
        send_long_idle(2);
        run_traffic(20);

        set_idle_timeout(16'd3);
        tick_odds = 5;
        run_traffic(30);

        // hold rsp while req keeps offering so the block backs up
        idling_on = 1'b0;
        hold_req = 1'b1;
        run_traffic(25);
        idling_on = 1'b1;

        set_idle_timeout(16'hFFFF);
        idling_on = 1'b0;
        send_long_idle(12);
        idling_on = 1'b1;
        tick_odds = 8;
        run_traffic(25);

        set_idle_timeout(hrp_pkg::TMO_W'($urandom_range(4, 30)));
        run_traffic(25);

        set_idle_timeout(16'd1);
        idling_on = 1'b0;
        run_traffic(20);

        release_req();
        wait (pending_rsp_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
